>>> hw/rtl/parking_distance_indicator_defines.svh
// ----------------------------------------------------------------------------
// Parking distance indicator: assertion macros
// Shorthand for the concurrent checks in the RTL; the user module must
// declare clock and reset.
// ----------------------------------------------------------------------------
`ifndef PARKING_DISTANCE_INDICATOR_DEFINES_SVH
`define PARKING_DISTANCE_INDICATOR_DEFINES_SVH

// same-cycle implication
`define PDI_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pdi: implication check failed");

// next-cycle implication
`define PDI_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pdi: next-cycle check failed");

`endif

>>> hw/rtl/pdi_pkg.sv
// ----------------------------------------------------------------------------
// pdi_pkg
// Widths, constants, register indexes and the divider interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package pdi_pkg;

   localparam int DIST_W     = 12;
   localparam int LEVEL_W    = 8;
   localparam int PCT_W      = 7;
   localparam int PAUSE_W    = 10;
   localparam int STILL_W    = 17;
   localparam int TIMEOUT_W  = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // shared divider: dividend < divisor * 2**QUOT_W is guaranteed by the caller
   localparam int DIVIDEND_W = 20;
   localparam int DIVISOR_W  = 12;
   localparam int QUOT_W     = 8;
   localparam int DIV_CNT_W  = $clog2(QUOT_W + 1);

   localparam logic [PCT_W-1:0]     PCT_FULL        = 7'd100;
   localparam logic [PCT_W-1:0]     PCT_NEAR        = 7'd10;
   localparam logic [PCT_W-1:0]     OCC_SET_PCT     = 7'd40;
   localparam logic [PCT_W-1:0]     OCC_RELEASE_PCT = 7'd80;
   localparam logic [DIST_W:0]      REV_MARGIN      = 13'd50;
   localparam logic [PAUSE_W-1:0]   PAUSE_NEAR      = 10'd10;
   localparam logic [PAUSE_W-1:0]   PAUSE_BASE      = 10'd50;
   localparam logic [STILL_W-1:0]   STILL_MAX       = '1;

   localparam logic [7:0]           RST_MOVE_EPS    = 8'd5;
   localparam logic [DIST_W-1:0]    RST_FULL_SCALE  = 12'd200;
   localparam logic [7:0]           RST_MIN_LIT     = 8'd1;
   localparam logic [PCT_W-1:0]     RST_SILENT_THR  = 7'd80;
   localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT     = 16'd5000;
   localparam logic [LEVEL_W-1:0]   RST_IDLE_BRIGHT = 8'd20;
   localparam logic [LEVEL_W-1:0]   RST_ACT_BRIGHT  = 8'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MOVE_EPSILON      = 3'd0,
      CSR_FULL_SCALE        = 3'd1,
      CSR_MIN_LIT_LEDS      = 3'd2,
      CSR_SILENT_THRESHOLD  = 3'd3,
      CSR_STILL_TIMEOUT     = 3'd4,
      CSR_IDLE_BRIGHTNESS   = 3'd5,
      CSR_ACTIVE_BRIGHTNESS = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

>>> hw/rtl/pdi_div.sv
// ----------------------------------------------------------------------------
// pdi_div
// Restoring divider, one quotient bit per cycle, QUOT_W-bit quotient.
// ----------------------------------------------------------------------------
`default_nettype none

`include "parking_distance_indicator_defines.svh"

module pdi_div
   import pdi_pkg::*;
(
   input  wire  logic                  clock,
   input  wire  logic                  reset,
   input  wire  div_ctl_type           ctl,
   input  wire  logic [DIVIDEND_W-1:0] dividend,
   input  wire  logic [DIVISOR_W-1:0]  divisor,
   output div_stat_type                stat,
   output logic [QUOT_W-1:0]           quotient
);

   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [QUOT_W-1:0]    acc_ff, acc_in;
   logic [DIVISOR_W-1:0] dsr_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   trial_sub;
   logic                 fits;

   // acc holds the unshifted dividend bits on top, quotient bits fill from below
   assign trial     = {rem_ff, acc_ff[QUOT_W-1]};
   assign trial_sub = trial - {1'b0, dsr_ff};
   assign fits      = trial >= {1'b0, dsr_ff};
   assign rem_in    = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
   assign acc_in    = {acc_ff[QUOT_W-2:0], fits};

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (ctl.start) begin
         rem_ff  <= dividend[DIVIDEND_W-1:QUOT_W];
         acc_ff  <= dividend[QUOT_W-1:0];
         dsr_ff  <= divisor;
         cnt_ff  <= DIV_CNT_W'(QUOT_W);
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         acc_ff <= acc_in;
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = acc_ff;

   `PDI_ASSERT_NXT(a_div_start_busy, ctl.start, busy_ff)
   `PDI_ASSERT_IMP(a_div_busy_count, busy_ff, cnt_ff != '0)
   `PDI_ASSERT_NXT(a_div_done_pulse, done_ff, !done_ff)

endmodule

`default_nettype wire

>>> hw/rtl/parking_distance_indicator.sv
// ----------------------------------------------------------------------------
// parking_distance_indicator
// Distance readings to LED bar, colors, buzzer pause and occupancy flags.
// ----------------------------------------------------------------------------
// Usage:
//  req_* beats carry either a 1 ms tick (req_kind = 0) or a reading pair
//  (req_kind = 1). A tick keeps req_ready high and produces no rsp beat. A reading
//  produces exactly one rsp beat with LED count, red/green levels, buzzer
//  state and the occupied/reversed flags after the update.
//  A reading runs three passes through one shared 8-step divider (percent,
//  lit LEDs, green level), only the last two when the near reading is at or
//  beyond full scale; each pass is a multiply state, a start state and 8
//  divide steps. req_ready is low while a reading is in flight.
//  The rsp beat sits in an output register; req_ready returns while it waits,
//  so ticks and the next reading are taken. A second result waits in the
//  final step until rsp_ready drains the first.
//  csr_* writes are always ready and take effect at once; write only while
//  no reading is in flight. Unknown indexes are dropped.
//  Synchronous reset restores register defaults and clears stillness timer,
//  last moving distance and both flags.
// ----------------------------------------------------------------------------
`default_nettype none

`include "parking_distance_indicator_defines.svh"

module parking_distance_indicator
   import pdi_pkg::*;
#(
   parameter int LED_COUNT = 30
)
(
   input  wire  logic                  clock,
   input  wire  logic                  reset,
   input  wire  logic                  req_valid,
   output logic                        req_ready,
   input  wire  logic                  req_kind,
   input  wire  logic [DIST_W-1:0]     req_near_distance,
   input  wire  logic [DIST_W-1:0]     req_far_distance,
   output logic                        rsp_valid,
   input  wire  logic                  rsp_ready,
   output logic [7:0]                  rsp_lit_leds,
   output logic [LEVEL_W-1:0]          rsp_red_level,
   output logic [LEVEL_W-1:0]          rsp_green_level,
   output logic                        rsp_buzzer_silent,
   output logic [PAUSE_W-1:0]          rsp_buzzer_pause,
   output logic                        rsp_occupied,
   output logic                        rsp_reversed,
   input  wire  logic                  csr_valid,
   output logic                        csr_ready,
   input  wire  logic [CSR_IDX_W-1:0]  csr_index,
   input  wire  logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic [7:0] LED_C = 8'(LED_COUNT);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_WAIT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_PCT,
      PH_LIT,
      PH_GRN
   } phase_type;

   // configuration
   logic [7:0]           move_eps_ff;
   logic [DIST_W-1:0]    full_scale_ff;
   logic [7:0]           min_lit_ff;
   logic [PCT_W-1:0]     silent_thr_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [LEVEL_W-1:0]   idle_bright_ff;
   logic [LEVEL_W-1:0]   act_bright_ff;

   // sequencer and item state
   state_type            state_ff;
   phase_type            phase_ff;
   logic [DIST_W-1:0]    last_dist_ff;
   logic [STILL_W-1:0]   still_ff;
   logic                 occupied_ff;
   logic                 reversed_ff;
   logic [DIST_W-1:0]    near_ff;
   logic [DIST_W-1:0]    far_ff;
   logic                 idle_ff;
   logic [LEVEL_W-1:0]   bright_ff;
   logic [PCT_W-1:0]     pct_ff;
   logic [7:0]           lit_ff;
   logic [LEVEL_W-1:0]   green_ff;
   logic [DIVIDEND_W-1:0] prod_ff;

   // result register
   logic                 rsp_valid_ff;
   logic [7:0]           rsp_lit_ff;
   logic [LEVEL_W-1:0]   rsp_red_ff;
   logic [LEVEL_W-1:0]   rsp_green_ff;
   logic                 rsp_silent_ff;
   logic [PAUSE_W-1:0]   rsp_pause_ff;

   // divider
   div_ctl_type          div_ctl;
   div_stat_type         div_stat;
   logic [DIVISOR_W-1:0] div_divisor;
   logic [QUOT_W-1:0]    div_quot;

   // datapath helpers
   logic                 req_take;
   logic [DIST_W-1:0]    diff_abs;
   logic                 moved;
   logic [STILL_W-1:0]   still_in;
   logic                 idle_in;
   logic [DIST_W-1:0]    mul_a;
   logic [7:0]           mul_b;
   logic [7:0]           floor_leds;
   logic [7:0]           lit_in;
   logic [PCT_W-1:0]     pct_off;
   logic                 silent_in;
   logic [PAUSE_W-1:0]   pause_in;
   logic                 occupied_in;
   logic                 reversed_in;
   logic                 rev_hit;
   logic                 out_free;

   // --------------------------------------------------------------------------
   // configuration port
   // --------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         move_eps_ff    <= RST_MOVE_EPS;
         full_scale_ff  <= RST_FULL_SCALE;
         min_lit_ff     <= RST_MIN_LIT;
         silent_thr_ff  <= RST_SILENT_THR;
         timeout_ff     <= RST_TIMEOUT;
         idle_bright_ff <= RST_IDLE_BRIGHT;
         act_bright_ff  <= RST_ACT_BRIGHT;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MOVE_EPSILON:      move_eps_ff    <= csr_data[7:0];
            CSR_FULL_SCALE:        full_scale_ff  <= csr_data[DIST_W-1:0];
            CSR_MIN_LIT_LEDS:      min_lit_ff     <= csr_data[7:0];
            CSR_SILENT_THRESHOLD:  silent_thr_ff  <= csr_data[PCT_W-1:0];
            CSR_STILL_TIMEOUT:     timeout_ff     <= csr_data[TIMEOUT_W-1:0];
            CSR_IDLE_BRIGHTNESS:   idle_bright_ff <= csr_data[LEVEL_W-1:0];
            CSR_ACTIVE_BRIGHTNESS: act_bright_ff  <= csr_data[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // --------------------------------------------------------------------------
   // accept-time logic: movement check and idle decision
   // --------------------------------------------------------------------------
   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;

   assign diff_abs = (last_dist_ff > req_near_distance) ? last_dist_ff - req_near_distance
                                                        : req_near_distance - last_dist_ff;
   assign moved    = diff_abs > {4'b0, move_eps_ff};
   assign still_in = moved ? '0 : still_ff;
   assign idle_in  = still_in > {1'b0, timeout_ff};

   // --------------------------------------------------------------------------
   // shared multiply operand and divisor select
   // --------------------------------------------------------------------------
   always_comb begin
      unique case (phase_ff)
         PH_PCT: begin
            mul_a       = near_ff;
            mul_b       = {1'b0, PCT_FULL};
            div_divisor = full_scale_ff;
         end
         PH_LIT: begin
            mul_a       = {{(DIST_W-PCT_W){1'b0}}, pct_ff};
            mul_b       = LED_C;
            div_divisor = {{(DIVISOR_W-PCT_W){1'b0}}, PCT_FULL};
         end
         default: begin
            mul_a       = {{(DIST_W-LEVEL_W){1'b0}}, bright_ff};
            mul_b       = {1'b0, pct_ff};
            div_divisor = {{(DIVISOR_W-PCT_W){1'b0}}, PCT_FULL};
         end
      endcase
   end

   assign div_ctl.start = (state_ff == ST_DIV);

   pdi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (prod_ff),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   // --------------------------------------------------------------------------
   // final step: floor, buzzer, occupancy
   // --------------------------------------------------------------------------
   assign floor_leds = (min_lit_ff > LED_C) ? LED_C : min_lit_ff;
   assign lit_in     = (lit_ff < floor_leds) ? floor_leds : lit_ff;
   assign pct_off    = pct_ff - PCT_NEAR;
   assign rev_hit    = {1'b0, far_ff} > ({1'b0, near_ff} + REV_MARGIN);

   always_comb begin
      priority if (idle_ff || (pct_ff >= PCT_NEAR && pct_ff > silent_thr_ff)) begin
         silent_in = 1'b1;
         pause_in  = '0;
      end else if (pct_ff < PCT_NEAR) begin
         silent_in = 1'b0;
         pause_in  = PAUSE_NEAR;
      end else begin
         // (p - 10) * 700 / 70 is exactly (p - 10) * 10
         silent_in = 1'b0;
         pause_in  = (PAUSE_W'(pct_off) << 3) + (PAUSE_W'(pct_off) << 1) + PAUSE_BASE;
      end
   end

   always_comb begin
      occupied_in = occupied_ff;
      reversed_in = reversed_ff;
      if (idle_ff) begin
         priority if (!occupied_ff && pct_ff < OCC_SET_PCT) begin
            occupied_in = 1'b1;
            reversed_in = rev_hit;
         end else if (occupied_ff && pct_ff > OCC_RELEASE_PCT) begin
            occupied_in = 1'b0;
            reversed_in = 1'b0;
         end else begin
            occupied_in = occupied_ff;
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // --------------------------------------------------------------------------
   // sequencer
   // --------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (!req_kind) begin
                  if (still_ff != STILL_MAX) begin
                     still_ff <= still_ff + 1'b1;
                  end
               end else begin
                  still_ff  <= still_in;
                  if (moved) begin
                     last_dist_ff <= req_near_distance;
                  end
                  near_ff   <= req_near_distance;
                  far_ff    <= req_far_distance;
                  idle_ff   <= idle_in;
                  bright_ff <= idle_in ? idle_bright_ff : act_bright_ff;
                  state_ff  <= ST_MUL;
                  // at or past full scale (or zero full scale) percent is 100
                  if (full_scale_ff == '0 || req_near_distance >= full_scale_ff) begin
                     pct_ff   <= PCT_FULL;
                     phase_ff <= PH_LIT;
                  end else begin
                     phase_ff <= PH_PCT;
                  end
               end
            end
         end
         ST_MUL: begin
            prod_ff  <= {{(DIVIDEND_W-DIST_W){1'b0}}, mul_a}
                        * {{(DIVIDEND_W-8){1'b0}}, mul_b};
            state_ff <= ST_DIV;
         end
         ST_DIV: begin
            state_ff <= ST_WAIT;
         end
         ST_WAIT: begin
            if (div_stat.done) begin
               unique case (phase_ff)
                  PH_PCT: begin
                     pct_ff   <= div_quot[PCT_W-1:0];
                     phase_ff <= PH_LIT;
                     state_ff <= ST_MUL;
                  end
                  PH_LIT: begin
                     lit_ff   <= div_quot;
                     phase_ff <= PH_GRN;
                     state_ff <= ST_MUL;
                  end
                  default: begin
                     green_ff <= div_quot;
                     state_ff <= ST_DONE;
                  end
               endcase
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_ff  <= 1'b1;
               rsp_lit_ff    <= lit_in;
               rsp_green_ff  <= green_ff;
               rsp_red_ff    <= bright_ff - green_ff;
               rsp_silent_ff <= silent_in;
               rsp_pause_ff  <= pause_in;
               occupied_ff   <= occupied_in;
               reversed_ff   <= reversed_in;
               state_ff      <= ST_IDLE;
            end
         end
         default: begin
            state_ff <= ST_IDLE;
         end
      endcase

      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_PCT;
         last_dist_ff <= '0;
         still_ff     <= '0;
         occupied_ff  <= 1'b0;
         reversed_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_lit_leds      = rsp_lit_ff;
   assign rsp_red_level     = rsp_red_ff;
   assign rsp_green_level   = rsp_green_ff;
   assign rsp_buzzer_silent = rsp_silent_ff;
   assign rsp_buzzer_pause  = rsp_pause_ff;
   assign rsp_occupied      = occupied_ff;
   assign rsp_reversed      = reversed_ff;

   `PDI_ASSERT_NXT(a_read_goes_busy, req_valid && req_ready && req_kind, !req_ready)
   `PDI_ASSERT_IMP(a_pct_in_range, state_ff != ST_IDLE && phase_ff != PH_PCT, pct_ff <= PCT_FULL)
   `PDI_ASSERT_IMP(a_release_only_idle, $fell(occupied_ff) && !$past(reset), $past(idle_ff))

endmodule

`default_nettype wire
